// ----- src/dmc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared constants and types for the direct-mapped write-back cache core.
// ----------------------------------------------------------------------------
package dmc_pkg;

   localparam int LINES      = 32;
   localparam int INDEX_BITS = $clog2(LINES);
   localparam int ADDR_BITS  = 16;
   localparam int TAG_BITS   = ADDR_BITS - INDEX_BITS;
   localparam int WORD_BITS  = 16;
   localparam int COUNT_BITS = 32;

   localparam logic [TAG_BITS-1:0] TAG_RESET = {TAG_BITS{1'b1}};

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   typedef logic [INDEX_BITS-1:0] index_type;
   typedef logic [TAG_BITS-1:0]   tag_type;
   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      tag_type  tag;
      logic     dirty;
      word_type word;
   } line_type;

   localparam line_type LINE_RESET = '{tag: TAG_RESET, dirty: 1'b1, word: '0};

   typedef struct packed {
      logic     is_write;
      addr_type address;
      word_type write_data;
      word_type fill_data;
   } request_type;

   typedef struct packed {
      logic      rd_en;
      index_type rd_index;
      logic      wr_en;
      index_type wr_index;
      line_type  wr_line;
   } store_ctrl_type;

endpackage

// ----- src/dmc_channels.sv -----
// ----------------------------------------------------------------------------
// dmc_req_if / dmc_rsp_if
// Valid/ready channels for cache access words and result words.
// ----------------------------------------------------------------------------
interface dmc_req_if import dmc_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     req_type;
   addr_type address;
   word_type write_data;
   word_type fill_data;

   modport source (output valid, output req_type, output address, output write_data,
                   output fill_data, input ready);
   modport sink (input valid, input req_type, input address, input write_data,
                 input fill_data, output ready);
endinterface

interface dmc_rsp_if import dmc_pkg::*; ();
   logic      valid;
   logic      ready;
   word_type  read_data;
   logic      was_hit;
   logic      memory_read;
   logic      writeback_valid;
   addr_type  writeback_address;
   word_type  writeback_data;
   count_type hit_count;
   count_type miss_count;
   count_type mem_read_count;
   count_type mem_write_count;

   modport source (output valid, output read_data, output was_hit, output memory_read,
                   output writeback_valid, output writeback_address,
                   output writeback_data, output hit_count, output miss_count,
                   output mem_read_count, output mem_write_count, input ready);
   modport sink (input valid, input read_data, input was_hit, input memory_read,
                 input writeback_valid, input writeback_address, input writeback_data,
                 input hit_count, input miss_count, input mem_read_count,
                 input mem_write_count, output ready);
endinterface

// ----- src/dmc_line_store.sv -----
// ----------------------------------------------------------------------------
// dmc_line_store
// Line memory (tag, dirty, word) with a registered read port and
// per-line valid bits; an unwritten line reads as the warm reset line.
// ----------------------------------------------------------------------------
module dmc_line_store import dmc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  store_ctrl_type ctrl,
   output line_type       rd_line
);

   line_type         mem [LINES];
   logic [LINES-1:0] valid_ff;
   line_type         rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_index] <= ctrl.wr_line;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[ctrl.rd_index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctrl.wr_en) begin
            valid_ff[ctrl.wr_index] <= 1'b1;
         end
         if (ctrl.rd_en) begin
            rd_valid_ff <= valid_ff[ctrl.rd_index];
         end
      end
   end

   assign rd_line = rd_valid_ff ? rd_data_ff : LINE_RESET;

endmodule

// ----- src/direct_mapped_write_back_cache_core.sv -----
// ----------------------------------------------------------------------------
// direct_mapped_write_back_cache_core
// Direct-mapped write-back cache, one word per line, with access counters.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one access word: kind (read/write), word address, write
//   data and the backing memory word for the address (used on a read miss).
//   rsp_ch returns one result word per access: read data, hit flag, fetch
//   flag, victim write-back (address and data) and four wrapping counters.
//   An access first reads the indexed line from the line memory
//   (registered read port), then compares tags, writes the line back and
//   loads the result register. req_ch.ready is high only in idle, so the
//   next access is taken only after this one has loaded its result.
//   A new access is taken while a finished result waits in the output
//   register; if the receiver stalls, the next access holds in lookup
//   until the result register frees, and req_ch.ready stays low.
//   Reset clears the counters and the line valid bits at once: every line
//   then reads as tag all ones, dirty, word zero. No clearing pass.
// ----------------------------------------------------------------------------
module direct_mapped_write_back_cache_core import dmc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dmc_req_if.sink   req_ch,
   dmc_rsp_if.source rsp_ch
);

   typedef enum logic {S_IDLE, S_LOOKUP} state_type;

   state_type      state_ff;
   request_type    req_ff;
   store_ctrl_type ctrl;
   line_type       line;

   logic      rsp_valid_ff;
   word_type  read_data_ff;
   logic      was_hit_ff;
   logic      memory_read_ff;
   logic      writeback_valid_ff;
   addr_type  writeback_address_ff;
   word_type  writeback_data_ff;
   count_type hit_count_ff;
   count_type miss_count_ff;
   count_type mem_read_count_ff;
   count_type mem_write_count_ff;

   tag_type   acc_tag;
   index_type acc_index;
   logic      hit;
   logic      do_writeback;
   logic      do_fetch;
   logic      slot_free;
   line_type  new_line;
   word_type  read_data_in;
   count_type hit_count_in;
   count_type miss_count_in;
   count_type mem_read_count_in;
   count_type mem_write_count_in;

   dmc_line_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .rd_line (line)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      acc_tag      = req_ff.address[ADDR_BITS-1:INDEX_BITS];
      acc_index    = req_ff.address[INDEX_BITS-1:0];
      hit          = (line.tag == acc_tag);
      do_writeback = !hit && line.dirty;
      do_fetch     = !hit && (req_ff.is_write == REQ_READ);

      new_line = line;
      if (req_ff.is_write == REQ_WRITE) begin
         new_line.tag   = acc_tag;
         new_line.dirty = 1'b1;
         new_line.word  = req_ff.write_data;
      end else if (!hit) begin
         new_line.tag   = acc_tag;
         new_line.dirty = 1'b0;
         new_line.word  = req_ff.fill_data;
      end

      read_data_in = '0;
      if (req_ff.is_write == REQ_READ) begin
         read_data_in = hit ? line.word : req_ff.fill_data;
      end

      hit_count_in       = hit_count_ff;
      miss_count_in      = miss_count_ff;
      mem_read_count_in  = mem_read_count_ff;
      mem_write_count_in = mem_write_count_ff;
      if (req_ff.is_write == REQ_READ) begin
         if (hit) begin
            hit_count_in = hit_count_ff + 1'b1;
         end else begin
            miss_count_in     = miss_count_ff + 1'b1;
            mem_read_count_in = mem_read_count_ff + 1'b1;
         end
      end
      if (do_writeback) begin
         mem_write_count_in = mem_write_count_ff + 1'b1;
      end

      ctrl.rd_en    = req_ch.valid && req_ch.ready;
      ctrl.rd_index = req_ch.address[INDEX_BITS-1:0];
      ctrl.wr_en    = (state_ff == S_LOOKUP) && slot_free;
      ctrl.wr_index = acc_index;
      ctrl.wr_line  = new_line;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         rsp_valid_ff       <= 1'b0;
         hit_count_ff       <= '0;
         miss_count_ff      <= '0;
         mem_read_count_ff  <= '0;
         mem_write_count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (req_ch.valid) begin
                  req_ff.is_write   <= req_ch.req_type;
                  req_ff.address    <= req_ch.address;
                  req_ff.write_data <= req_ch.write_data;
                  req_ff.fill_data  <= req_ch.fill_data;
                  state_ff          <= S_LOOKUP;
               end
            end
            S_LOOKUP: begin
               if (slot_free) begin
                  rsp_valid_ff         <= 1'b1;
                  read_data_ff         <= read_data_in;
                  was_hit_ff           <= hit;
                  memory_read_ff       <= do_fetch;
                  writeback_valid_ff   <= do_writeback;
                  writeback_address_ff <= do_writeback ? {line.tag, acc_index} : '0;
                  writeback_data_ff    <= do_writeback ? line.word : '0;
                  hit_count_ff         <= hit_count_in;
                  miss_count_ff        <= miss_count_in;
                  mem_read_count_ff    <= mem_read_count_in;
                  mem_write_count_ff   <= mem_write_count_in;
                  state_ff             <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.read_data         = read_data_ff;
   assign rsp_ch.was_hit           = was_hit_ff;
   assign rsp_ch.memory_read       = memory_read_ff;
   assign rsp_ch.writeback_valid   = writeback_valid_ff;
   assign rsp_ch.writeback_address = writeback_address_ff;
   assign rsp_ch.writeback_data    = writeback_data_ff;
   assign rsp_ch.hit_count         = hit_count_ff;
   assign rsp_ch.miss_count        = miss_count_ff;
   assign rsp_ch.mem_read_count    = mem_read_count_ff;
   assign rsp_ch.mem_write_count   = mem_write_count_ff;

endmodule
